[hdl/s20fi_pkg.sv]
package s20fi_pkg;

  localparam int unsigned WordW     = 32;
  localparam int unsigned NumWords  = 16;
  localparam int unsigned RoundW    = 5;
  localparam int unsigned MaxRounds = 20;
  localparam int unsigned CfgW      = 5;

  // Quarter-round rotation amounts
  localparam int unsigned RotA = 7;
  localparam int unsigned RotB = 9;
  localparam int unsigned RotC = 13;
  localparam int unsigned RotD = 18;

  // Configuration register indexes
  localparam logic CfgTopRound  = 1'b0;
  localparam logic CfgStopRound = 1'b1;

  // Quarter-round step codes: which of (a, b, c, d) gets updated
  localparam logic [1:0] OpUpdB = 2'd0;
  localparam logic [1:0] OpUpdC = 2'd1;
  localparam logic [1:0] OpUpdD = 2'd2;
  localparam logic [1:0] OpUpdA = 2'd3;

  typedef logic [WordW-1:0] word_t;
  typedef word_t [NumWords-1:0] state_t;

  typedef struct packed {
    logic       col;  // column round when set, row round otherwise
    logic [1:0] op;
  } step_ctrl_t;

  function automatic logic [RoundW-1:0] sat_rounds(logic [RoundW-1:0] v);
    return (v > RoundW'(MaxRounds)) ? RoundW'(MaxRounds) : v;
  endfunction

  // Word index of position pos within quarter-round q; rows are the transpose of columns
  function automatic logic [3:0] word_idx(logic col, logic [1:0] q, logic [1:0] pos);
    logic [1:0] m;
    m = q + pos;
    return col ? {m, q} : {q, m};
  endfunction

  function automatic word_t rotl_op(word_t v, logic [1:0] op);
    word_t r;
    case (op)
      OpUpdB:  r = (v << RotA) | (v >> (WordW - RotA));
      OpUpdC:  r = (v << RotB) | (v >> (WordW - RotB));
      OpUpdD:  r = (v << RotC) | (v >> (WordW - RotC));
      default: r = (v << RotD) | (v >> (WordW - RotD));
    endcase
    return r;
  endfunction

endpackage

[hdl/salsa20_core_forward_inverse_top.sv]
// Each input beat runs R rounds, then in forward mode the feedforward add when enabled;
// R is the forward round count or top minus stop in inverse mode (0 to 20).
// The block takes no new beat until the last result is in the output register;
// the shared four-lane quarter-round unit does one add-rotate-xor step per
// cycle, four steps per round. A stalled result holds off the next input beat.
// Reset: asynchronous active low; clears control, top round to 20, stop round to 0.
module salsa20_core_forward_inverse_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          func_i,
  input  logic [s20fi_pkg::RoundW-1:0]  round_count_i,
  input  logic                          feed_forward_i,
  input  logic [63:0]                   in_pair0_i,
  input  logic [63:0]                   in_pair1_i,
  input  logic [63:0]                   in_pair2_i,
  input  logic [63:0]                   in_pair3_i,
  input  logic [63:0]                   in_pair4_i,
  input  logic [63:0]                   in_pair5_i,
  input  logic [63:0]                   in_pair6_i,
  input  logic [63:0]                   in_pair7_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [63:0]                   out_pair0_o,
  output logic [63:0]                   out_pair1_o,
  output logic [63:0]                   out_pair2_o,
  output logic [63:0]                   out_pair3_o,
  output logic [63:0]                   out_pair4_o,
  output logic [63:0]                   out_pair5_o,
  output logic [63:0]                   out_pair6_o,
  output logic [63:0]                   out_pair7_o,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [s20fi_pkg::CfgW-1:0]    cfg_data_i
);
  import s20fi_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRun  = 2'd1;
  localparam logic [1:0] StFeed = 2'd2;
  localparam logic [1:0] StDone = 2'd3;

  logic [1:0]        state_q, state_d;
  state_t            x_q, x_d;
  state_t            orig_q, orig_d;
  state_t            out_q, out_d;
  logic              out_valid_q, out_valid_d;
  logic [1:0]        step_q, step_d;
  logic [RoundW-1:0] round_q, round_d;
  logic [RoundW-1:0] rem_q, rem_d;
  logic              ff_q, ff_d;
  logic              inv_q, inv_d;
  logic [CfgW-1:0]   top_q, stop_q;

  state_t            in_state;
  state_t            step_state;
  state_t            fed_state;
  step_ctrl_t        step_ctrl;
  logic              in_beat;
  logic              out_free;
  logic [RoundW-1:0] top_sat, stop_sat;

  assign in_stall_o = (state_q != StIdle);
  assign in_beat    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign top_sat    = sat_rounds(top_q);
  assign stop_sat   = sat_rounds(stop_q);

  always_comb begin
    in_state[0]  = in_pair0_i[31:0];
    in_state[1]  = in_pair0_i[63:32];
    in_state[2]  = in_pair1_i[31:0];
    in_state[3]  = in_pair1_i[63:32];
    in_state[4]  = in_pair2_i[31:0];
    in_state[5]  = in_pair2_i[63:32];
    in_state[6]  = in_pair3_i[31:0];
    in_state[7]  = in_pair3_i[63:32];
    in_state[8]  = in_pair4_i[31:0];
    in_state[9]  = in_pair4_i[63:32];
    in_state[10] = in_pair5_i[31:0];
    in_state[11] = in_pair5_i[63:32];
    in_state[12] = in_pair6_i[31:0];
    in_state[13] = in_pair6_i[63:32];
    in_state[14] = in_pair7_i[31:0];
    in_state[15] = in_pair7_i[63:32];
  end

  // Inverse mode walks the steps of a round backward
  assign step_ctrl.col = round_q[0];
  assign step_ctrl.op  = inv_q ? ~step_q : step_q;

  s20fi_round_step u_step (
    .state_i (x_q),
    .ctrl_i  (step_ctrl),
    .state_o (step_state)
  );

  always_comb begin
    for (int i = 0; i < NumWords; i++) begin
      fed_state[i] = x_q[i] + orig_q[i];
    end
  end

  always_comb begin
    state_d     = state_q;
    x_d         = x_q;
    orig_d      = orig_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    step_d      = step_q;
    round_d     = round_q;
    rem_d       = rem_q;
    ff_d        = ff_q;
    inv_d       = inv_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (in_beat) begin
          x_d     = in_state;
          orig_d  = in_state;
          inv_d   = func_i;
          ff_d    = feed_forward_i && !func_i;
          step_d  = OpUpdB;
          state_d = StRun;
          if (func_i) begin
            round_d = top_sat;
            rem_d   = (top_sat > stop_sat) ? top_sat - stop_sat : '0;
          end else begin
            round_d = RoundW'(1);
            rem_d   = sat_rounds(round_count_i);
          end
        end
      end
      StRun: begin
        if (rem_q == '0) begin
          state_d = ff_q ? StFeed : StDone;
        end else begin
          x_d    = step_state;
          step_d = step_q + 2'd1;
          if (step_q == OpUpdA) begin
            rem_d   = rem_q - RoundW'(1);
            round_d = inv_q ? round_q - RoundW'(1) : round_q + RoundW'(1);
          end
        end
      end
      StFeed: begin
        x_d     = fed_state;
        state_d = StDone;
      end
      StDone: begin
        // hold until the output register frees up
        if (out_free) begin
          out_d       = x_q;
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      step_q      <= '0;
      round_q     <= '0;
      rem_q       <= '0;
      ff_q        <= 1'b0;
      inv_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      step_q      <= step_d;
      round_q     <= round_d;
      rem_q       <= rem_d;
      ff_q        <= ff_d;
      inv_q       <= inv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    orig_q <= orig_d;
    out_q  <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q  <= CfgW'(MaxRounds);
      stop_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgTopRound:  top_q  <= cfg_data_i;
        CfgStopRound: stop_q <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_pair0_o = {out_q[1],  out_q[0]};
  assign out_pair1_o = {out_q[3],  out_q[2]};
  assign out_pair2_o = {out_q[5],  out_q[4]};
  assign out_pair3_o = {out_q[7],  out_q[6]};
  assign out_pair4_o = {out_q[9],  out_q[8]};
  assign out_pair5_o = {out_q[11], out_q[10]};
  assign out_pair6_o = {out_q[13], out_q[12]};
  assign out_pair7_o = {out_q[15], out_q[14]};

`ifndef ASSERT_OFF
  a_beat_starts_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> (state_q == StRun) && (step_q == OpUpdB))
    else $error("accepted beat did not start the round sequencer");

  a_no_feed_inverse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFeed) |-> !inv_q)
    else $error("feedforward reached in inverse mode");

  a_round_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRun) |->
      (round_q <= RoundW'(MaxRounds + 1)) && (rem_q <= RoundW'(MaxRounds)))
    else $error("round counter out of range");

  a_run_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRun) && (rem_q == '0) && !ff_q |=> (state_q == StDone))
    else $error("sequencer did not finish after the last round");
`endif

endmodule

[hdl/s20fi_round_step.sv]
module s20fi_round_step (
  input  s20fi_pkg::state_t     state_i,
  input  s20fi_pkg::step_ctrl_t ctrl_i,
  output s20fi_pkg::state_t     state_o
);
  import s20fi_pkg::*;

  logic [3:0] t_idx [4];
  logic [3:0] p_idx [4];
  logic [3:0] r_idx [4];
  word_t      sum   [4];
  word_t      upd   [4];

  // Four independent quarter-rounds, one add-rotate-xor each
  always_comb begin
    state_o = state_i;
    for (int q = 0; q < 4; q++) begin
      t_idx[q] = word_idx(ctrl_i.col, 2'(q), ctrl_i.op + 2'd1);
      p_idx[q] = word_idx(ctrl_i.col, 2'(q), ctrl_i.op);
      r_idx[q] = word_idx(ctrl_i.col, 2'(q), ctrl_i.op - 2'd1);
      sum[q]   = state_i[p_idx[q]] + state_i[r_idx[q]];
      upd[q]   = state_i[t_idx[q]] ^ rotl_op(sum[q], ctrl_i.op);
      state_o[t_idx[q]] = upd[q];
    end
  end

endmodule

[bench/tb.sv]
`timescale 1ns / 100ps

module tb;
  import s20fi_pkg::*;

  localparam bit FuncFwd = 1'b0;
  localparam bit FuncInv = 1'b1;

  localparam int CycleLimit   = 500_000;
  localparam int LongHold     = 300;
  localparam int SettleCycles = 8;
  localparam int DrainCycles  = 120;
  localparam int NumPhases    = 6;
  localparam int PhaseBeats   = 75;
  localparam int MaxPrinted   = 40;

  typedef logic [7:0][63:0] pairs_t;
  typedef logic [NumWords-1:0][WordW-1:0] words_t;

  typedef struct {
    bit                func;
    logic [RoundW-1:0] rounds;
    bit                ff;
    pairs_t            pairs;
  } block_in_t;

  typedef struct {
    bit              set_cfg;
    logic [CfgW-1:0] top;
    logic [CfgW-1:0] stop;
    block_in_t       blk;
    bit              rand_data;
    bit              fixed;
    pairs_t          want;
  } stim_row_t;

  // Quarter-round word order (a, b, c, d), four entries per quarter
  localparam logic [3:0] ColQuads [16] = '{0, 4, 8, 12, 5, 9, 13, 1,
                                           10, 14, 2, 6, 15, 3, 7, 11};
  localparam logic [3:0] RowQuads [16] = '{0, 1, 2, 3, 5, 6, 7, 4,
                                           10, 11, 8, 9, 15, 12, 13, 14};

  localparam pairs_t PatZero  = '0;
  localparam pairs_t PatOnes  = '1;
  localparam pairs_t PatAlt   = {8{64'h55555555_aaaaaaaa}};
  localparam pairs_t PatWrap  = {8{64'h80000000_ffffffff}};
  localparam pairs_t PatWrap2 = {8{64'h00000000_fffffffe}};
  localparam pairs_t PatCount = {64'h0f0f0f0f_0e0e0e0e, 64'h0d0d0d0d_0c0c0c0c,
                                 64'h0b0b0b0b_0a0a0a0a, 64'h09090909_08080808,
                                 64'h07070707_06060606, 64'h05050505_04040404,
                                 64'h03030303_02020202, 64'h01010101_00000000};

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic              func_i = 1'b0;
  logic [RoundW-1:0] round_count_i = '0;
  logic              feed_forward_i = 1'b0;
  logic [63:0]       in_pair0_i = '0;
  logic [63:0]       in_pair1_i = '0;
  logic [63:0]       in_pair2_i = '0;
  logic [63:0]       in_pair3_i = '0;
  logic [63:0]       in_pair4_i = '0;
  logic [63:0]       in_pair5_i = '0;
  logic [63:0]       in_pair6_i = '0;
  logic [63:0]       in_pair7_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b1;
  logic [63:0]       out_pair0_o;
  logic [63:0]       out_pair1_o;
  logic [63:0]       out_pair2_o;
  logic [63:0]       out_pair3_o;
  logic [63:0]       out_pair4_o;
  logic [63:0]       out_pair5_o;
  logic [63:0]       out_pair6_o;
  logic [63:0]       out_pair7_o;
  logic              cfg_we_i = 1'b0;
  logic              cfg_idx_i = CfgTopRound;
  logic [CfgW-1:0]   cfg_data_i = '0;

  // Local copy of the round registers
  logic [CfgW-1:0] top_cfg = 5'd20;
  logic [CfgW-1:0] stop_cfg = 5'd0;

  pairs_t    expected_q [$];
  stim_row_t stim_rows [$];
  int        mismatches = 0;
  int        results_seen = 0;
  int        cycle_cnt = 0;
  int        hold_req = 0;
  int        hold_seen = 0;
  int        hold_run = 0;
  int        stall_run = 0;
  bit        stall_lvl = 1'b0;
  pairs_t    seen_pairs;
  pairs_t    want_pairs;

  salsa20_core_forward_inverse_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .func_i         (func_i),
    .round_count_i  (round_count_i),
    .feed_forward_i (feed_forward_i),
    .in_pair0_i     (in_pair0_i),
    .in_pair1_i     (in_pair1_i),
    .in_pair2_i     (in_pair2_i),
    .in_pair3_i     (in_pair3_i),
    .in_pair4_i     (in_pair4_i),
    .in_pair5_i     (in_pair5_i),
    .in_pair6_i     (in_pair6_i),
    .in_pair7_i     (in_pair7_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_pair0_o    (out_pair0_o),
    .out_pair1_o    (out_pair1_o),
    .out_pair2_o    (out_pair2_o),
    .out_pair3_o    (out_pair3_o),
    .out_pair4_o    (out_pair4_o),
    .out_pair5_o    (out_pair5_o),
    .out_pair6_o    (out_pair6_o),
    .out_pair7_o    (out_pair7_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic word_t rotl(word_t v, int unsigned s);
    return (v << s) | (v >> (WordW - s));
  endfunction

  function automatic int unsigned clip_rounds(logic [CfgW-1:0] v);
    return (v > MaxRounds) ? MaxRounds : int'(v);
  endfunction

  // One column or row round, or its exact inverse when undo is set
  function automatic words_t salsa_round(words_t x, bit col, bit undo);
    logic [3:0] a, b, c, d;
    int q, i;
    for (i = 0; i < 4; i++) begin
      q = undo ? 3 - i : i;
      a = col ? ColQuads[q*4]     : RowQuads[q*4];
      b = col ? ColQuads[q*4 + 1] : RowQuads[q*4 + 1];
      c = col ? ColQuads[q*4 + 2] : RowQuads[q*4 + 2];
      d = col ? ColQuads[q*4 + 3] : RowQuads[q*4 + 3];
      if (!undo) begin
        x[b] = x[b] ^ rotl(x[a] + x[d], RotA);
        x[c] = x[c] ^ rotl(x[b] + x[a], RotB);
        x[d] = x[d] ^ rotl(x[c] + x[b], RotC);
        x[a] = x[a] ^ rotl(x[d] + x[c], RotD);
      end else begin
        x[a] = x[a] ^ rotl(x[d] + x[c], RotD);
        x[d] = x[d] ^ rotl(x[c] + x[b], RotC);
        x[c] = x[c] ^ rotl(x[b] + x[a], RotB);
        x[b] = x[b] ^ rotl(x[a] + x[d], RotA);
      end
    end
    return x;
  endfunction

  function automatic pairs_t salsa_expect(block_in_t blk, logic [CfgW-1:0] top,
                                          logic [CfgW-1:0] stop);
    words_t      orig, x;
    int unsigned n, k;
    int          i;
    orig = words_t'(blk.pairs);
    x = orig;
    if (blk.func == FuncFwd) begin
      n = clip_rounds(blk.rounds);
      for (k = 1; k <= n; k++) x = salsa_round(x, k[0], 1'b0);
      if (blk.ff) begin
        for (i = 0; i < NumWords; i++) x[i] = x[i] + orig[i];
      end
    end else begin
      for (k = clip_rounds(top); k > clip_rounds(stop); k--) x = salsa_round(x, k[0], 1'b1);
    end
    return pairs_t'(x);
  endfunction

  function automatic pairs_t rand_pairs();
    words_t w;
    int     r;
    for (int i = 0; i < NumWords; i++) begin
      r = $urandom_range(0, 19);
      w[i] = (r == 0) ? '0 : (r == 1) ? '1 : word_t'($urandom());
    end
    return pairs_t'(w);
  endfunction

  function automatic block_in_t rand_block();
    block_in_t blk;
    blk.func = ($urandom_range(0, 99) < 65) ? FuncFwd : FuncInv;
    blk.rounds = ($urandom_range(0, 6) == 0) ? RoundW'($urandom_range(21, 31))
                                             : RoundW'($urandom_range(0, 20));
    blk.ff = 1'($urandom_range(0, 1));
    blk.pairs = rand_pairs();
    return blk;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  task automatic add_row(bit set_cfg, logic [CfgW-1:0] top, logic [CfgW-1:0] stop,
                         bit func, logic [RoundW-1:0] rounds, bit ff, bit rand_data,
                         pairs_t pairs, bit fixed, pairs_t want);
    stim_row_t row;
    row.set_cfg = set_cfg;
    row.top = top;
    row.stop = stop;
    row.blk.func = func;
    row.blk.rounds = rounds;
    row.blk.ff = ff;
    row.blk.pairs = pairs;
    row.rand_data = rand_data;
    row.fixed = fixed;
    row.want = want;
    stim_rows.push_back(row);
  endtask

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= MaxPrinted) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Offer one beat and hold it until accepted
  task automatic drive_beat(block_in_t blk, pairs_t want);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    func_i <= blk.func;
    round_count_i <= blk.rounds;
    feed_forward_i <= blk.ff;
    in_pair0_i <= blk.pairs[0];
    in_pair1_i <= blk.pairs[1];
    in_pair2_i <= blk.pairs[2];
    in_pair3_i <= blk.pairs[3];
    in_pair4_i <= blk.pairs[4];
    in_pair5_i <= blk.pairs[5];
    in_pair6_i <= blk.pairs[6];
    in_pair7_i <= blk.pairs[7];
    do @(posedge clk_i); while (in_stall_o);
    expected_q.push_back(want);
  endtask

  task automatic idle_input(int n);
    repeat (n) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
  endtask

  // Drop valid and wait until every pending result is out
  task automatic quiesce();
    idle_input(1);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [CfgW-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgTopRound) top_cfg = val;
    else stop_cfg = val;
  endtask

  task automatic set_rounds(logic [CfgW-1:0] top, logic [CfgW-1:0] stop);
    quiesce();
    write_reg(CfgTopRound, top);
    write_reg(CfgStopRound, stop);
  endtask

  // Receiver: random stall runs, quiet stretches, and a long hold on request
  always @(negedge clk_i) begin
    int r;
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_run = LongHold;
    end
    if (hold_run > 0) begin
      hold_run--;
      out_stall_i <= 1'b1;
    end else begin
      if (stall_run == 0) begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          stall_lvl = 1'b0;
          stall_run = $urandom_range(1, 12);
        end else if (r < 85) begin
          stall_lvl = 1'b1;
          stall_run = $urandom_range(1, 3);
        end else if (r < 93) begin
          stall_lvl = 1'b1;
          stall_run = $urandom_range(10, 60);
        end else begin
          stall_lvl = 1'b0;
          stall_run = $urandom_range(100, 300);
        end
      end
      stall_run--;
      out_stall_i <= stall_lvl;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen_pairs = {out_pair7_o, out_pair6_o, out_pair5_o, out_pair4_o,
                    out_pair3_o, out_pair2_o, out_pair1_o, out_pair0_o};
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing pending", results_seen));
      end else begin
        want_pairs = expected_q.pop_front();
        for (int p = 0; p < 8; p++) begin
          if (seen_pairs[p] !== want_pairs[p]) begin
            report_mismatch($sformatf("result %0d out_pair%0d got %h expected %h",
                                      results_seen, p, seen_pairs[p], want_pairs[p]));
          end
        end
      end
      results_seen++;
    end
  end

  initial begin : watchdog
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    stim_row_t       row;
    block_in_t       blk;
    pairs_t          want;
    logic [CfgW-1:0] top, stop;

    // forward: zero rounds, zero state, saturation, single and paired rounds
    add_row(0, 0, 0, FuncFwd, 5'd0,  0, 0, PatCount, 1, PatCount);
    add_row(0, 0, 0, FuncFwd, 5'd0,  1, 0, PatWrap,  1, PatWrap2);
    add_row(0, 0, 0, FuncFwd, 5'd20, 0, 0, PatZero,  1, PatZero);
    add_row(0, 0, 0, FuncFwd, 5'd20, 1, 0, PatZero,  1, PatZero);
    add_row(0, 0, 0, FuncFwd, 5'd20, 1, 0, PatOnes,  0, PatZero);
    add_row(0, 0, 0, FuncFwd, 5'd1,  0, 0, PatCount, 0, PatZero);
    add_row(0, 0, 0, FuncFwd, 5'd2,  0, 0, PatCount, 0, PatZero);
    add_row(0, 0, 0, FuncFwd, 5'd31, 0, 0, PatAlt,   0, PatZero);
    add_row(0, 0, 0, FuncFwd, 5'd21, 1, 1, PatZero,  0, PatZero);
    add_row(0, 0, 0, FuncFwd, 5'd8,  1, 1, PatZero,  0, PatZero);
    // inverse at reset settings, feedforward ignored
    add_row(0, 0, 0, FuncInv, 5'd0,  0, 0, PatCount, 0, PatZero);
    add_row(0, 0, 0, FuncInv, 5'd31, 1, 0, PatOnes,  0, PatZero);
    // stop not below top once both saturate at 20: state passes through
    add_row(1, 5'd5,  5'd5,  FuncInv, 5'd0, 0, 0, PatAlt,   1, PatAlt);
    add_row(1, 5'd3,  5'd7,  FuncInv, 5'd9, 0, 0, PatCount, 1, PatCount);
    add_row(1, 5'd0,  5'd31, FuncInv, 5'd0, 1, 0, PatOnes,  1, PatOnes);
    add_row(1, 5'd31, 5'd25, FuncInv, 5'd0, 1, 0, PatCount, 1, PatCount);
    add_row(1, 5'd0,  5'd0,  FuncInv, 5'd0, 0, 0, PatZero,  1, PatZero);
    // saturated top, single rounds at either end, then one forward and one mid-range inverse row
    add_row(1, 5'd31, 5'd0,  FuncInv, 5'd0,  0, 1, PatZero, 0, PatZero);
    add_row(1, 5'd1,  5'd0,  FuncInv, 5'd0,  0, 1, PatZero, 0, PatZero);
    add_row(1, 5'd20, 5'd19, FuncInv, 5'd0,  0, 0, PatAlt,  0, PatZero);
    add_row(0, 0, 0,         FuncFwd, 5'd19, 0, 1, PatZero, 0, PatZero);
    add_row(1, 5'd13, 5'd2,  FuncInv, 5'd7,  1, 1, PatZero, 0, PatZero);

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (stim_rows[i]) begin
      row = stim_rows[i];
      if (row.set_cfg) set_rounds(row.top, row.stop);
      blk = row.blk;
      if (row.rand_data) blk.pairs = rand_pairs();
      want = row.fixed ? row.want : salsa_expect(blk, top_cfg, stop_cfg);
      drive_beat(blk, want);
      idle_input(pick_gap());
    end

    for (int phase = 0; phase < NumPhases; phase++) begin
      case (phase)
        0: begin
          top = 5'd20;
          stop = 5'd0;
        end
        1: begin
          top = 5'd31;
          stop = 5'd0;
        end
        default: begin
          top = CfgW'($urandom_range(0, 31));
          stop = ($urandom_range(0, 3) == 0) ? CfgW'($urandom_range(0, 31))
                                             : CfgW'($urandom_range(0, top));
        end
      endcase
      set_rounds(top, stop);
      // hold the receiver off and keep offering beats so the block backs up
      if (phase == 2) hold_req++;
      for (int n = 0; n < PhaseBeats; n++) begin
        blk = rand_block();
        drive_beat(blk, salsa_expect(blk, top_cfg, stop_cfg));
        if (!(phase == 2 && n < 15) && phase != 4) idle_input(pick_gap());
      end
    end

    idle_input(1);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
